// ----- rtl/vector_moving_average_filter_assert.svh -----
// assertion macros used by the checker file
`ifndef VECTOR_MOVING_AVERAGE_FILTER_ASSERT_SVH
`define VECTOR_MOVING_AVERAGE_FILTER_ASSERT_SVH

// same-cycle implication
`define VMAF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("vmaf assertion failed");

// next-cycle implication
`define VMAF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("vmaf assertion failed");

`endif

// ----- rtl/vmaf_pkg.sv -----
// shared constants and types of the vector moving average filter
package vmaf_pkg;

  localparam int unsigned MAX_WINDOW_DEF  = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned WLEN_W     = 5;
  localparam int unsigned COEF_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WLEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF = 2'd2;

  localparam logic [COEF_W-1:0] Q16_ONE  = 17'h10000;
  localparam logic [WLEN_W-1:0] WLEN_RST = 5'd16;
  localparam logic [COEF_W-1:0] COEF_RST = 17'h08000;

  typedef struct packed {
    logic load;
    logic clear;
    logic rd;
    logic upd;
    logic dinit;
    logic dstep;
    logic dfin;
    logic emul;
    logic efin;
  } lane_ctl_t;

endpackage

// ----- rtl/vmaf_ram.sv -----
// generic single-write, single-read ram with registered read data
module vmaf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/vmaf_lane.sv -----
// one component lane: history column, running sum, serial divider, exponential smoother
module vmaf_lane #(
  parameter int unsigned MAX_WINDOW  = vmaf_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = vmaf_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vmaf_pkg::lane_ctl_t           ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [SLOT_W-1:0]             slot_i,
  input  logic                          full_i,
  input  logic [CNT_W-1:0]              count_i,
  input  logic [vmaf_pkg::COEF_W-1:0]   coef_i,
  output logic signed [SAMPLE_BITS-1:0] res_o
);
  import vmaf_pkg::*;

  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_W + 1;
  localparam int unsigned T_W    = PROD_W + 1;

  logic signed [SAMPLE_BITS-1:0] smp_q, prev_q, res_q, old_w;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic [SUM_W-1:0]              mag_q, mag_d, sum_u, quo_w;
  logic                          neg_q;
  logic [CNT_W-1:0]              rem_q, rem_d;
  logic [CNT_W:0]                trial_w, div_w;
  logic                          ge_w;
  logic signed [COEF_W:0]        coef_s, comp_s;
  logic [COEF_W-1:0]             comp_w;
  logic signed [PROD_W-1:0]      m1_q, m2_q, prod1_w, prod2_w;
  logic signed [T_W-1:0]         t_w, sh_w;

  vmaf_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ctl_i.upd),
    .waddr_i(slot_i),
    .wdata_i(smp_q),
    .re_i   (ctl_i.rd),
    .raddr_i(slot_i),
    .rdata_o(old_w)
  );

  // running sum: drop the oldest sample once the window is full
  assign sum_d = sum_q + SUM_W'(smp_q) - (full_i ? SUM_W'(old_w) : SUM_W'(0));

  // restoring division of the magnitude, one quotient bit per step
  assign sum_u   = sum_q;
  assign trial_w = {rem_q, mag_q[SUM_W-1]};
  assign div_w   = {1'b0, count_i};
  assign ge_w    = (trial_w >= div_w);
  assign rem_d   = ge_w ? CNT_W'(trial_w - div_w) : trial_w[CNT_W-1:0];
  assign mag_d   = {mag_q[SUM_W-2:0], ge_w};
  assign quo_w   = neg_q ? SUM_W'(~mag_q + 1'b1) : mag_q;

  // exponential smoothing
  assign comp_w  = Q16_ONE - coef_i;
  assign coef_s  = {1'b0, coef_i};
  assign comp_s  = {1'b0, comp_w};
  assign prod1_w = PROD_W'(smp_q) * PROD_W'(coef_s);
  assign prod2_w = PROD_W'(prev_q) * PROD_W'(comp_s);
  assign t_w     = T_W'(m1_q) + T_W'(m2_q);
  assign sh_w    = t_w >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
    end else if (ctl_i.clear) begin
      sum_q  <= '0;
      prev_q <= '0;
    end else begin
      if (ctl_i.upd) begin
        sum_q <= sum_d;
      end
      if (ctl_i.efin) begin
        prev_q <= sh_w[SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      smp_q <= sample_i;
    end
    if (ctl_i.dinit) begin
      neg_q <= sum_q[SUM_W-1];
      mag_q <= sum_q[SUM_W-1] ? SUM_W'(~sum_u + 1'b1) : sum_u;
      rem_q <= '0;
    end else if (ctl_i.dstep) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
    if (ctl_i.dfin) begin
      res_q <= quo_w[SAMPLE_BITS-1:0];
    end else if (ctl_i.efin) begin
      res_q <= sh_w[SAMPLE_BITS-1:0];
    end
    if (ctl_i.emul) begin
      m1_q <= prod1_w;
      m2_q <= prod2_w;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/vector_moving_average_filter.sv -----
// top level of the vector moving average filter: control, config, lanes and output merge
// Smooths signed x/y/z samples, one transaction in and one out. Mean mode reads
// the oldest sample from each lane's ring ram, updates the running sums and
// divides them by the sample count in a restoring divider that yields one
// quotient bit per cycle; one item is processed at a time.
// Exponential mode registers the two products and then shifts their sum.
// The three components run in parallel lanes. A finished result waits in the
// output register while the next item is taken. A write to a defined register
// restarts the history; the ring needs no clearing pass.
module vector_moving_average_filter #(
  parameter int unsigned MAX_WINDOW  = vmaf_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = vmaf_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned DATA_W = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // sample_x, sample_y, sample_z
  input  logic [DATA_W-1:0]              s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // filtered_x, filtered_y, filtered_z
  output logic [DATA_W-1:0]              m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vmaf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vmaf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import vmaf_pkg::*;

  localparam int unsigned SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MRD   = 4'd1;
  localparam logic [3:0] ST_MUPD  = 4'd2;
  localparam logic [3:0] ST_DINIT = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_DFIN  = 4'd5;
  localparam logic [3:0] ST_EMUL  = 4'd6;
  localparam logic [3:0] ST_EFIN  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]        state_q, state_d;
  logic              mode_q;
  logic [WLEN_W-1:0] wlen_q;
  logic [COEF_W-1:0] coef_q, coef_eff;
  logic [SLOT_W-1:0] wslot_q, slot_q, slot_w;
  logic [CNT_W-1:0]  held_q, win_w, nxt_w;
  logic              full_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic              in_acc, cfg_acc, cfg_hit, out_free;
  logic              m_tvalid_q;
  logic [DATA_W-1:0] m_tdata_q;
  lane_ctl_t         ctl;
  logic [2:0][SAMPLE_BITS-1:0] res_pk;

  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign cfg_hit       = cfg_acc && ((cfg_index_i == REG_MODE) || (cfg_index_i == REG_WLEN) ||
                                     (cfg_index_i == REG_COEF));
  assign out_free      = !m_tvalid_q || m_axis_tready;

  // effective window and coefficient
  always_comb begin
    if (32'(wlen_q) > 32'(MAX_WINDOW)) begin
      win_w = CNT_W'(MAX_WINDOW);
    end else if (wlen_q == '0) begin
      win_w = CNT_W'(1);
    end else begin
      win_w = CNT_W'(wlen_q);
    end
    coef_eff = (coef_q > Q16_ONE) ? Q16_ONE : coef_q;
  end

  assign slot_w = (CNT_W'(wslot_q) >= win_w) ? '0 : wslot_q;
  assign nxt_w  = CNT_W'(slot_q) + CNT_W'(1);

  always_comb begin
    ctl       = '0;
    ctl.load  = in_acc;
    ctl.clear = cfg_hit;
    ctl.rd    = (state_q == ST_MRD);
    ctl.upd   = (state_q == ST_MUPD);
    ctl.dinit = (state_q == ST_DINIT);
    ctl.dstep = (state_q == ST_DIV);
    ctl.dfin  = (state_q == ST_DFIN);
    ctl.emul  = (state_q == ST_EMUL);
    ctl.efin  = (state_q == ST_EFIN);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = mode_q ? ST_EMUL : ST_MRD;
        end
      end
      ST_MRD:   state_d = ST_MUPD;
      ST_MUPD:  state_d = ST_DINIT;
      ST_DINIT: state_d = ST_DIV;
      ST_DIV: begin
        if (dcnt_q == '0) begin
          state_d = ST_DFIN;
        end
      end
      ST_DFIN:  state_d = ST_OUT;
      ST_EMUL:  state_d = ST_EFIN;
      ST_EFIN:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= 1'b0;
      wlen_q     <= WLEN_RST;
      coef_q     <= COEF_RST;
      wslot_q    <= '0;
      held_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        case (cfg_index_i)
          REG_MODE: mode_q <= cfg_data_i[0];
          REG_WLEN: wlen_q <= cfg_data_i[WLEN_W-1:0];
          REG_COEF: coef_q <= cfg_data_i[COEF_W-1:0];
          default:  mode_q <= mode_q;
        endcase
      end
      if (cfg_hit) begin
        wslot_q <= '0;
        held_q  <= '0;
      end else if (state_q == ST_MUPD) begin
        wslot_q <= (nxt_w >= win_w) ? '0 : SLOT_W'(nxt_w);
        if (!full_q) begin
          held_q <= held_q + CNT_W'(1);
        end
      end
      if (state_q == ST_OUT && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q <= slot_w;
      full_q <= (held_q >= win_w);
    end
    if (state_q == ST_DINIT) begin
      dcnt_q <= DCNT_W'(SUM_W - 1);
    end else if (state_q == ST_DIV) begin
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
    if (state_q == ST_OUT && out_free) begin
      m_tdata_q <= DATA_W'(res_pk);
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    vmaf_lane #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .sample_i(s_axis_tdata[l*SAMPLE_BITS +: SAMPLE_BITS]),
      .slot_i  (slot_q),
      .full_i  (full_q),
      .count_i (held_q),
      .coef_i  (coef_eff),
      .res_o   (res_pk[l])
    );
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

// ----- rtl/vmaf_checker.sv -----
// port-level checker of the vector moving average filter and its bind
`include "vector_moving_average_filter_assert.svh"

module vmaf_checker #(
  parameter int unsigned SAMPLE_BITS = vmaf_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned DATA_W = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_tvalid_i,
  input logic              s_tready_i,
  input logic              m_tvalid_i,
  input logic              m_tready_i,
  input logic [DATA_W-1:0] m_tdata_i,
  input logic              cfg_valid_i,
  input logic              cfg_ready_i
);

  // a stalled result stays put
  `VMAF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i))

  // one item at a time: busy right after a transaction
  `VMAF_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, s_tvalid_i && s_tready_i, !s_tready_i && !cfg_ready_i)

  // config write and input transaction never share an edge
  `VMAF_ASSERT_IMPL(a_cfg_excl, clk_i, rst_ni, cfg_valid_i && cfg_ready_i, !(s_tvalid_i && s_tready_i))

endmodule

bind vector_moving_average_filter vmaf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_vmaf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_i(cfg_ready_o)
);
